// ===== rtl/core/gsa_pkg.sv =====
// Shared types and constants for the GTS slot allocator and beacon field builder.
package gsa_pkg;

    localparam int MAX_ENTRIES_DEF = 7;
    localparam int LAST_SLOT       = 15;
    localparam int CNT_W           = 3;
    localparam int SLOT_W          = 5;
    localparam int ADDR_W          = 16;
    localparam int LEN_W           = 4;
    localparam int BYTE_W          = 8;

    localparam logic [SLOT_W-1:0] FIRST_CFP_RESET = SLOT_W'(LAST_SLOT + 1);
    localparam logic [LEN_W-1:0]  LEN_MAX         = LEN_W'(LAST_SLOT);
    localparam logic [BYTE_W-1:0] SPEC_PERMIT_BIT = 8'h80;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_EMIT  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_INVALID = 2'd2,
        ST_CFP     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CHAIN_HOLD   = 2'd0,
        CHAIN_PUSH   = 2'd1,
        CHAIN_ROTATE = 2'd2
    } chain_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_SCAN,
        S_COMMIT,
        S_SPEC,
        S_MASK,
        S_ENTRY,
        S_RESTORE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic              dir;
    } entry_t;

endpackage

// ===== rtl/core/gsa_cell.sv =====
// One table cell: holds a single GTS entry and shifts it toward either neighbor.
module gsa_cell (
    input  logic                clk,
    input  gsa_pkg::chain_cmd_t cmd,
    input  gsa_pkg::entry_t     from_prev,
    input  gsa_pkg::entry_t     from_next,
    output gsa_pkg::entry_t     entry
);
    import gsa_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        case (cmd)
            CHAIN_PUSH:   entry_next = from_prev;
            CHAIN_ROTATE: entry_next = from_next;
            default:      entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/gsa_chain.sv =====
// Row of table cells: push at the head, rotate left for scans and emits.
module gsa_chain #(
    parameter int MAX_ENTRIES = gsa_pkg::MAX_ENTRIES_DEF
) (
    input  logic                   clk,
    input  gsa_pkg::chain_cmd_t    cmd,
    input  gsa_pkg::entry_t        push_entry,
    output gsa_pkg::entry_t        head,
    output logic [MAX_ENTRIES-1:0] dir_vec
);
    import gsa_pkg::*;

    entry_t cells [MAX_ENTRIES];

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;

        // head takes the new entry on a push; head wraps to the tail on a rotate
        if (i == 0)
        begin : g_head
            assign prev_e = push_entry;
        end
        else
        begin : g_body
            assign prev_e = cells[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign next_e = cells[0];
        end
        else
        begin : g_inner
            assign next_e = cells[i+1];
        end

        gsa_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .from_prev (prev_e),
            .from_next (next_e),
            .entry     (cells[i])
        );

        assign dir_vec[i] = cells[i].dir;
    end

    assign head = cells[0];

endmodule

// ===== rtl/core/gts_slot_allocator_field_builder.sv =====
// Top level of the coordinator GTS slot allocator and beacon GTS field builder.
//
// Keeps a table of up to MAX_ENTRIES guaranteed time slot allocations in a row
// of cells, newest at the head, and a first free contention-free slot pointer
// that starts at 16. Each input transfer carries an op in tuser: clear empties
// the table, add carves slot_len slots downward from the first free slot and
// pushes the entry at the head, emit streams the beacon GTS field (spec byte,
// direction mask, then three descriptor bytes per entry, newest first). Every
// item gives one result transfer, except an emit with permit set, which gives
// 1, or 2 + 3*count bytes; tlast marks the final one. Status codes: 0 ok,
// 1 duplicate address/direction pair (table unchanged), 2 invalid length or
// unused op, 3 table full or not enough contention-free slots. Items are taken
// one at a time. Clear, a rejected add, op 3, and an emit with permit off or
// with an empty table give their one result without moving the chain; an add
// that passes its checks rotates the whole chain once for the duplicate scan;
// an emit of count entries rotates the chain once per entry and then on until
// the full turn brings it home. A loaded result that waits on m_axis_tready
// holds back the next one. The output register lets the next item be taken
// while the final result still waits. gts_permit is written through
// cfg_valid/cfg_data, always ready, and must only change while the block
// is idle.
module gts_slot_allocator_field_builder #(
    parameter int MAX_ENTRIES = gsa_pkg::MAX_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // gts_permit
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // short_addr[15:0], slot_len[19:16], direction[20]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // status[1:0], field_byte[9:2]
    output logic        m_axis_tlast
);
    import gsa_pkg::*;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(MAX_ENTRIES - 1);

    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [SLOT_W-1:0]   ffree_reg,  ffree_next;
    logic                permit_reg, permit_next;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic [1:0]          sel_reg,    sel_next;
    logic                dup_reg,    dup_next;
    status_t             pend_reg,   pend_next;
    logic                ovalid_reg, ovalid_next;

    // payload, no reset
    logic [ADDR_W-1:0]   req_addr_reg, req_addr_next;
    logic [LEN_W-1:0]    req_len_reg,  req_len_next;
    logic                req_dir_reg,  req_dir_next;
    status_t             ostat_reg,    ostat_next;
    logic [BYTE_W-1:0]   obyte_reg,    obyte_next;
    logic                olast_reg,    olast_next;

    chain_cmd_t              chain_cmd;
    entry_t                  push_entry;
    entry_t                  head;
    logic [MAX_ENTRIES-1:0]  dir_vec;

    logic                in_xfer;
    logic                out_free;
    logic                head_hit;
    logic [SLOT_W-1:0]   need_slots;
    logic [SLOT_W-1:0]   ffree_carved;
    logic [BYTE_W-1:0]   mask_byte;
    logic                entry_last;

    gsa_chain #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_chain (
        .clk        (clk),
        .cmd        (chain_cmd),
        .push_entry (push_entry),
        .head       (head),
        .dir_vec    (dir_vec)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, obyte_reg, ostat_reg};
    assign m_axis_tlast  = olast_reg;

    assign need_slots   = {1'b0, s_axis_tdata[19:16]} + SLOT_W'(1);
    assign ffree_carved = ffree_reg - {1'b0, req_len_reg};
    assign head_hit     = (idx_reg < count_reg) && (head.addr == req_addr_reg)
                          && (head.dir == req_dir_reg);
    assign entry_last   = (sel_reg == 2'd2) && (idx_reg == count_reg - CNT_W'(1));

    assign push_entry.addr  = req_addr_reg;
    assign push_entry.start = ffree_carved[LEN_W-1:0];
    assign push_entry.len   = req_len_reg;
    assign push_entry.dir   = req_dir_reg;

    // direction mask: bit i follows entry i while it is occupied
    always_comb
    begin
        mask_byte = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            mask_byte[i] = dir_vec[i] && (CNT_W'(i) < count_reg);
        end
        mask_byte[BYTE_W-1] = 1'b0;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ffree_next    = ffree_reg;
        permit_next   = permit_reg;
        idx_next      = idx_reg;
        sel_next      = sel_reg;
        dup_next      = dup_reg;
        pend_next     = pend_reg;
        ovalid_next   = ovalid_reg && !m_axis_tready;
        req_addr_next = req_addr_reg;
        req_len_next  = req_len_reg;
        req_dir_next  = req_dir_reg;
        ostat_next    = ostat_reg;
        obyte_next    = obyte_reg;
        olast_next    = olast_reg;
        chain_cmd     = CHAIN_HOLD;

        if (cfg_valid && cfg_ready)
        begin
            permit_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    req_addr_next = s_axis_tdata[15:0];
                    req_len_next  = s_axis_tdata[19:16];
                    req_dir_next  = s_axis_tdata[20];
                    idx_next      = '0;
                    sel_next      = '0;
                    dup_next      = 1'b0;
                    state_next    = S_RESP;
                    unique case (op_t'(s_axis_tuser))
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ffree_next = FIRST_CFP_RESET;
                            pend_next  = ST_OK;
                        end
                        OP_ADD:
                        begin
                            if (s_axis_tdata[19:16] > LEN_MAX)
                            begin
                                pend_next = ST_INVALID;
                            end
                            else if (count_reg >= CNT_FULL || ffree_reg < need_slots)
                            begin
                                pend_next = ST_CFP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_EMIT:
                        begin
                            pend_next = ST_OK;
                            if (permit_reg)
                            begin
                                state_next = S_SPEC;
                            end
                        end
                        default:
                        begin
                            pend_next = ST_INVALID;
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = pend_reg;
                    obyte_next  = '0;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            // compare the head, rotate; a full turn brings the table home
            S_SCAN:
            begin
                chain_cmd = CHAIN_ROTATE;
                dup_next  = dup_reg || head_hit;
                idx_next  = idx_reg + CNT_W'(1);
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_COMMIT;
                end
            end

            S_COMMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = '0;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                    if (dup_reg)
                    begin
                        ostat_next = ST_DUP;
                    end
                    else
                    begin
                        ostat_next = ST_OK;
                        chain_cmd  = CHAIN_PUSH;
                        ffree_next = ffree_carved;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end

            S_SPEC:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = ST_OK;
                    obyte_next  = SPEC_PERMIT_BIT | {{(BYTE_W-CNT_W){1'b0}}, count_reg};
                    olast_next  = (count_reg == '0);
                    state_next  = (count_reg == '0) ? S_IDLE : S_MASK;
                end
            end

            S_MASK:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = ST_OK;
                    obyte_next  = mask_byte;
                    olast_next  = 1'b0;
                    state_next  = S_ENTRY;
                end
            end

            // three descriptor bytes from the head, then rotate the next entry in
            S_ENTRY:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = ST_OK;
                    olast_next  = entry_last;
                    case (sel_reg)
                        2'd0:    obyte_next = head.addr[7:0];
                        2'd1:    obyte_next = head.addr[15:8];
                        default: obyte_next = {head.len, head.start};
                    endcase
                    if (sel_reg == 2'd2)
                    begin
                        chain_cmd = CHAIN_ROTATE;
                        sel_next  = '0;
                        idx_next  = idx_reg + CNT_W'(1);
                        if (entry_last)
                        begin
                            state_next = (count_reg == CNT_FULL) ? S_IDLE : S_RESTORE;
                        end
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
            end

            // finish the turn so the newest entry sits at the head again
            S_RESTORE:
            begin
                chain_cmd = CHAIN_ROTATE;
                idx_next  = idx_reg + CNT_W'(1);
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ffree_reg  <= FIRST_CFP_RESET;
            permit_reg <= 1'b0;
            idx_reg    <= '0;
            sel_reg    <= '0;
            dup_reg    <= 1'b0;
            pend_reg   <= ST_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ffree_reg  <= ffree_next;
            permit_reg <= permit_next;
            idx_reg    <= idx_next;
            sel_reg    <= sel_next;
            dup_reg    <= dup_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_addr_reg <= req_addr_next;
        req_len_reg  <= req_len_next;
        req_dir_reg  <= req_dir_next;
        ostat_reg    <= ostat_next;
        obyte_reg    <= obyte_next;
        olast_reg    <= olast_next;
    end

endmodule

// ===== rtl/core/gsa_checker.sv =====
// Port-level checks for the GTS slot allocator, bound to the top level.
module gsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import gsa_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a non-ok status is a single-result item with no field byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |->
            m_axis_tlast && m_axis_tdata[9:2] == 8'd0)
        else $error("error status with field byte or without last");

    // bytes inside a beacon field stream carry status ok
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[1:0] == ST_OK)
        else $error("non-final result with error status");

    // one item at a time: busy in the cycle after a request transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in progress");

endmodule

bind gts_slot_allocator_field_builder gsa_checker u_gsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/gts_slot_allocator_field_builder_tb.sv =====
// Self-checking testbench for the GTS slot allocator and beacon GTS field builder.
module gts_slot_allocator_field_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsa_pkg::*;

    // op code with no operation behind it; the block answers it with ST_INVALID
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Longest tail after the final result of an item: an emit goes on rotating
    // the chain back home after its last byte.
    localparam int HOLDOFF_CYCLES = 40;
    // Slowest passing run: ~175 items, 23 bytes each, receiver idling 81 percent
    // of the time, plus the drain pauses; taken several times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [1:0] status;
        logic [7:0] fbyte;
        logic       last;
    } gts_result_t;

    // Scoreboard: mirrors the GTS table and the permit bit, turns each
    // accepted request into the result transfers it must produce, and
    // checks the result stream against them in order.
    class gts_table_scoreboard;
        logic [15:0]  tab_addr  [MAX_ENTRIES_DEF];
        logic [3:0]   tab_start [MAX_ENTRIES_DEF];
        logic [3:0]   tab_len   [MAX_ENTRIES_DEF];
        logic         tab_dir   [MAX_ENTRIES_DEF];
        int unsigned  tab_count;
        logic [4:0]   free_slot;
        logic         permit;
        gts_result_t  expected_q[$];
        int unsigned  mismatches;

        function new();
            tab_count   = 0;
            free_slot   = FIRST_CFP_RESET;
            permit      = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_permit(logic value);
            permit = value;
        endfunction

        function void queue_result(logic [1:0] status, logic [7:0] fbyte, logic last);
            gts_result_t r;
            r.status = status;
            r.fbyte  = fbyte;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        function logic [1:0] add_allocation(logic [15:0] addr, logic [3:0] len, logic dir);
            if (len > LEN_MAX)
                return ST_INVALID;
            // room is checked before the duplicate scan
            if (tab_count >= MAX_ENTRIES_DEF || int'(free_slot) < int'(len) + 1)
                return ST_CFP;
            for (int i = 0; i < tab_count; i++)
                if (tab_addr[i] == addr && tab_dir[i] == dir)
                    return ST_DUP;
            // carve downward, then push the new entry at the head
            free_slot = free_slot - 5'(len);
            for (int i = tab_count; i > 0; i--)
            begin
                tab_addr[i]  = tab_addr[i-1];
                tab_start[i] = tab_start[i-1];
                tab_len[i]   = tab_len[i-1];
                tab_dir[i]   = tab_dir[i-1];
            end
            tab_addr[0]  = addr;
            tab_start[0] = free_slot[3:0];
            tab_len[0]   = len;
            tab_dir[0]   = dir;
            tab_count++;
            return ST_OK;
        endfunction

        function void predict_gts_field();
            logic [7:0] field_q[$];
            logic [6:0] mask;
            if (!permit)
            begin
                queue_result(ST_OK, 8'h00, 1'b1);
                return;
            end
            field_q.push_back(SPEC_PERMIT_BIT | 8'(tab_count));
            if (tab_count > 0)
            begin
                mask = '0;
                for (int i = 0; i < tab_count; i++)
                    mask[i] = tab_dir[i];
                field_q.push_back({1'b0, mask});
                for (int i = 0; i < tab_count; i++)
                begin
                    field_q.push_back(tab_addr[i][7:0]);
                    field_q.push_back(tab_addr[i][15:8]);
                    field_q.push_back({tab_len[i], tab_start[i]});
                end
            end
            foreach (field_q[k])
                queue_result(ST_OK, field_q[k], k == field_q.size() - 1);
        endfunction

        function void note_request(logic [1:0] op, logic [15:0] addr, logic [3:0] len,
                                   logic dir);
            case (op)
                OP_CLEAR:
                begin
                    tab_count = 0;
                    free_slot = FIRST_CFP_RESET;
                    queue_result(ST_OK, 8'h00, 1'b1);
                end
                OP_ADD:  queue_result(add_allocation(addr, len, dir), 8'h00, 1'b1);
                OP_EMIT: predict_gts_field();
                default: queue_result(ST_INVALID, 8'h00, 1'b1);
            endcase
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [15:0] data, logic last);
            gts_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result tdata=%h tlast=%b", data, last));
                return;
            end
            want = expected_q.pop_front();
            if (data[1:0] !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", data[1:0], want.status));
            if (data[9:2] !== want.fbyte)
                report_mismatch($sformatf("field byte %h, expected %h", data[9:2], want.fbyte));
            if (last !== want.last)
                report_mismatch($sformatf("tlast %b, expected %b", last, want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // short_addr[15:0], slot_len[19:16], direction[20]
    logic [1:0]  s_axis_tuser = '0;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // status[1:0], field_byte[9:2]
    logic        m_axis_tlast;

    gts_table_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cycle_count = 0;

    gts_slot_allocator_field_builder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    // Stall the result stream at the current rate, one decision per cycle.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Check every result transfer; values read here are the pre-edge ones.
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Idle the request side at the current rate, then hold one request until
    // it is taken. tvalid stays high across back-to-back transfers.
    task automatic issue_request(logic [1:0] op, logic [15:0] addr, logic [3:0] len,
                                 logic dir);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, dir, len, addr};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(op, addr, len, dir);
    endtask

    // Drop tvalid and hold until every expected result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Write gts_permit once the block is idle, chain rotation included.
    task automatic write_permit(logic value);
        wait_drained();
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_permit(value);
    endtask

    // Directed requests: extremes of every field, every op, and the corner
    // cases (zero length, slots exhausted, duplicate pair, full table checked
    // ahead of the duplicate scan, unused op, emit of empty and full tables).
    task automatic run_directed();
        issue_request(OP_EMIT,   16'h0000, 4'd0,  1'b0);  // empty table: spec byte only
        issue_request(OP_UNUSED, 16'hFFFF, 4'd15, 1'b1);
        issue_request(OP_ADD,    16'h0000, 4'd0,  1'b0);  // zero length, start wraps to 0
        issue_request(OP_ADD,    16'hFFFF, 4'd15, 1'b1);  // takes every slot down to 1
        issue_request(OP_ADD,    16'h1234, 4'd1,  1'b0);  // not enough slots left
        issue_request(OP_ADD,    16'hFFFF, 4'd0,  1'b1);  // same pair again
        issue_request(OP_ADD,    16'hFFFF, 4'd0,  1'b0);  // same address, other direction
        issue_request(OP_ADD,    16'h0000, 4'd0,  1'b1);
        issue_request(OP_EMIT,   16'hFFFF, 4'd15, 1'b1);
        issue_request(OP_ADD,    16'hA5A5, 4'd0,  1'b1);
        issue_request(OP_ADD,    16'h5A5A, 4'd0,  1'b0);
        issue_request(OP_ADD,    16'h00FF, 4'd0,  1'b1);  // table now full
        issue_request(OP_ADD,    16'h8001, 4'd0,  1'b0);  // full table
        issue_request(OP_ADD,    16'h0000, 4'd0,  1'b0);  // full wins over duplicate
        issue_request(OP_EMIT,   16'h0000, 4'd0,  1'b0);  // longest field, 23 bytes
        issue_request(OP_CLEAR,  16'hFFFF, 4'd15, 1'b1);
        issue_request(OP_EMIT,   16'h0000, 4'd0,  1'b0);
        issue_request(OP_ADD,    16'h4321, 4'd8,  1'b1);
        issue_request(OP_ADD,    16'h4322, 4'd8,  1'b1);  // 8 left, 9 needed
        issue_request(OP_ADD,    16'h4323, 4'd7,  1'b0);
        issue_request(OP_EMIT,   16'h0000, 4'd0,  1'b0);
        write_permit(1'b0);
        issue_request(OP_EMIT,   16'hFFFF, 4'd15, 1'b1);  // permit off: single zero byte
        issue_request(OP_CLEAR,  16'h0000, 4'd0,  1'b0);
        issue_request(OP_ADD,    16'hBEEF, 4'd3,  1'b1);
        issue_request(OP_EMIT,   16'h0000, 4'd0,  1'b0);
    endtask

    // Random requests: mostly adds and emits on a live table, with clears to
    // start over, duplicate pairs taken from the table, and noise ops.
    task automatic run_random(int count);
        int          pick;
        logic [1:0]  op;
        logic [15:0] addr;
        logic [3:0]  len;
        logic        dir;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            addr = 16'($urandom());
            dir  = 1'($urandom());
            len  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 3));
            if (pick < 8)
                op = OP_CLEAR;
            else if (pick < 13)
                op = OP_UNUSED;
            else if (pick < 40)
                op = OP_EMIT;
            else
            begin
                op = OP_ADD;
                // reuse an address already in the table to provoke duplicates
                if (sb.tab_count > 0 && $urandom_range(0, 3) == 0)
                    addr = sb.tab_addr[$urandom_range(0, sb.tab_count - 1)];
            end
            issue_request(op, addr, len, dir);
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver stalls heavily
        send_idle_pct = 24;
        recv_idle_pct = 81;
        write_permit(1'b1);
        run_directed();
        write_permit(1'b1);
        run_random(RANDOM_PER_PHASE);

        // the other way round, with the permit off
        write_permit(1'b0);
        send_idle_pct = 81;
        recv_idle_pct = 24;
        run_random(RANDOM_PER_PHASE);

        // full rate on both sides
        write_permit(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_PER_PHASE);

        wait_drained();
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
